### rtl/core/mm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mm_pkg
// Types, constants and helpers shared by the matrix multiplier modules.
// ============================================================================
package mm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 3;              // bits of a row or column index
  localparam int ADDR_W    = 2 * IDX_W;      // store address {row, col}
  localparam int DIM_W     = 4;              // width of a dimension register
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + 4;     // headroom for MAX_DIM products
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [DATA_W-1:0] product_value;
    logic                    last_element;
    logic                    dimension_error;
  } out_item_t;

  // Control that travels down the multiply-accumulate pipeline with the data.
  typedef struct packed {
    logic             first;      // first term of a dot product
    logic             last_k;     // last term of a dot product
    logic             last_elem;  // last element of the product
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_ctl_t;

  // Highest index of a walk for a dimension register; 0 counts as 1 and
  // anything above MAX_DIM counts as MAX_DIM.
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
    logic [IDX_W-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (int'(d) > MAX_DIM) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(d - DIM_W'(1));
    end
    return r;
  endfunction

endpackage

### rtl/core/mm_store.sv
`timescale 1ns / 1ps
// ============================================================================
// mm_store
// Element stores of matrices A and B: one write port shared by both, one
// registered read port on each.
// ============================================================================
module mm_store (
  input  logic                         clk,
  input  logic                         we_a,
  input  logic                         we_b,
  input  logic [mm_pkg::ADDR_W-1:0]    waddr,
  input  logic signed [mm_pkg::DATA_W-1:0] wdata,
  input  logic [mm_pkg::ADDR_W-1:0]    raddr_a,
  input  logic [mm_pkg::ADDR_W-1:0]    raddr_b,
  output logic signed [mm_pkg::DATA_W-1:0] rdata_a,
  output logic signed [mm_pkg::DATA_W-1:0] rdata_b
);
  import mm_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic signed [DATA_W-1:0] mem_a [DEPTH];
  logic signed [DATA_W-1:0] mem_b [DEPTH];

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    rdata_a <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    rdata_b <= mem_b[raddr_b];
  end

endmodule

### rtl/core/mm_mac.sv
`timescale 1ns / 1ps
// ============================================================================
// mm_mac
// Multiply-accumulate pipeline: registered multiply, wide accumulate, then
// fraction shift and saturation into the result register.
// ============================================================================
module mm_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  mm_pkg::mac_ctl_t                 in_ctl,
  input  logic signed [mm_pkg::DATA_W-1:0] op_a,
  input  logic signed [mm_pkg::DATA_W-1:0] op_b,
  output logic                             res_valid,
  output mm_pkg::out_item_t                res
);
  import mm_pkg::*;

  logic                     mul_valid;
  mac_ctl_t                 mul_ctl;
  logic signed [PROD_W-1:0] prod;

  logic                     acc_valid;
  mac_ctl_t                 acc_ctl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;

  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_W:0]    upper;
  logic signed [DATA_W-1:0] sat_value;

  always_comb begin
    if (mul_ctl.first) begin
      acc_next = ACC_W'(prod);
    end else begin
      acc_next = acc + ACC_W'(prod);
    end
  end

  // Arithmetic shift rounds toward minus infinity; the value fits when all
  // bits above the result's sign bit agree with it.
  always_comb begin
    shifted = acc >>> FRAC_BITS;
    upper   = shifted[ACC_W-1:DATA_W-1];
    if (upper == '0 || upper == '1) begin
      sat_value = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      acc_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      mul_valid <= in_valid;
      acc_valid <= mul_valid;
      res_valid <= acc_valid && acc_ctl.last_k;
    end
  end

  always_ff @(posedge clk) begin
    mul_ctl <= in_ctl;
    prod    <= op_a * op_b;
    if (mul_valid) begin
      acc <= acc_next;
    end
    acc_ctl <= mul_ctl;
    res.out_row         <= acc_ctl.row;
    res.out_col         <= acc_ctl.col;
    res.product_value   <= sat_value;
    res.last_element    <= acc_ctl.last_elem;
    res.dimension_error <= 1'b0;
  end

endmodule

### rtl/core/matrix_multiply.sv
`timescale 1ns / 1ps
// ============================================================================
// matrix_multiply
// Fixed-point general matrix multiply, C = A * B, up to 8 x 8, Q15.16.
// ============================================================================
// Usage: an item is taken when start is high and busy is low. A load item
// (mode 0 for A, mode 1 for B) writes one element into its store; busy
// stays low, so loads can follow each other every cycle.
// A compute item (mode 2) raises busy and walks the product row-major. The
// inner products run through one multiply-accumulate unit fed by one read
// port on each store, so a compute of an M x N by N x P product makes
// M*P*N store read pairs, and busy falls once the final element has left
// the pipeline, and product elements come out in walk order. Results are
// shown for exactly one cycle with result_valid high and cannot be held
// off: the receiver must take every one of them.
// The final element carries last_element. When a_cols differs from b_rows
// a compute instead yields a single result in the cycle after it is taken
// with dimension_error and last_element set and zero in the other fields.
// Dimension registers of 0 count as 1 and values above 8 count as 8 for
// the walk; the error check compares the raw values. The stores are not
// cleared by reset: every element that a compute reads must have been
// loaded beforehand. Configuration writes are always accepted
// (cfg_ready is high) and must only happen while the block is idle.
// ============================================================================
module matrix_multiply (
  input  logic                         clk,
  input  logic                         rst,
  // Command channel
  input  logic                         start,
  output logic                         busy,
  input  mm_pkg::in_item_t             cmd,
  // Result strobe
  output logic                         result_valid,
  output mm_pkg::out_item_t            result,
  // Configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]     cfg_data
);
  import mm_pkg::*;

  // Dimension registers, reset to the full 8 x 8 size.
  logic [DIM_W-1:0] a_rows;
  logic [DIM_W-1:0] a_cols;
  logic [DIM_W-1:0] b_rows;
  logic [DIM_W-1:0] b_cols;

  state_t state;
  state_t state_next;

  logic accept;
  logic is_compute;
  logic load_ok;
  logic issue;

  // Walk bounds, latched when a compute starts.
  logic [IDX_W-1:0] m_last;
  logic [IDX_W-1:0] n_last;
  logic [IDX_W-1:0] p_last;

  // Walk counters: i is the product row, j the product column, k the term.
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic             last_k;
  logic             last_j;
  logic             last_i;

  // Control that lines up with the registered store read data.
  logic     rd_valid;
  mac_ctl_t rd_ctl;

  logic signed [DATA_W-1:0] rdata_a;
  logic signed [DATA_W-1:0] rdata_b;

  logic      mac_valid;
  out_item_t mac_res;

  logic      err_valid;
  out_item_t err_res;

  assign cfg_ready  = 1'b1;
  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign is_compute = (cmd.mode == MODE_COMPUTE);
  assign load_ok    = (int'(cmd.row_index) < MAX_DIM) && (int'(cmd.col_index) < MAX_DIM);
  assign issue      = (state == ST_RUN);

  assign last_k = (k == n_last);
  assign last_j = (j == p_last);
  assign last_i = (i == m_last);

  // Sequencer: RUN issues one store read pair per cycle, DRAIN waits for the
  // final element to leave the multiply-accumulate pipeline.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_compute && (a_cols == b_rows)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_k && last_j && last_i) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_valid && mac_res.last_element) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      a_rows    <= DIM_W'(MAX_DIM);
      a_cols    <= DIM_W'(MAX_DIM);
      b_rows    <= DIM_W'(MAX_DIM);
      b_cols    <= DIM_W'(MAX_DIM);
      rd_valid  <= 1'b0;
      err_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_valid  <= issue;
      err_valid <= accept && is_compute && (a_cols != b_rows);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_A_ROWS: a_rows <= cfg_data;
          CFG_A_COLS: a_cols <= cfg_data;
          CFG_B_ROWS: b_rows <= cfg_data;
          CFG_B_COLS: b_cols <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Walk counters and the control word that follows each read.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      m_last <= dim_last(a_rows);
      n_last <= dim_last(a_cols);
      p_last <= dim_last(b_cols);
      i      <= '0;
      j      <= '0;
      k      <= '0;
    end else if (issue) begin
      if (!last_k) begin
        k <= k + IDX_W'(1);
      end else begin
        k <= '0;
        if (!last_j) begin
          j <= j + IDX_W'(1);
        end else begin
          j <= '0;
          i <= i + IDX_W'(1);
        end
      end
    end
    rd_ctl.first     <= (k == '0);
    rd_ctl.last_k    <= last_k;
    rd_ctl.last_elem <= last_k && last_j && last_i;
    rd_ctl.row       <= i;
    rd_ctl.col       <= j;
  end

  always_ff @(posedge clk) begin
    err_res.out_row         <= '0;
    err_res.out_col         <= '0;
    err_res.product_value   <= '0;
    err_res.last_element    <= 1'b1;
    err_res.dimension_error <= 1'b1;
  end

  // Element (r, c) lives at address {r, c}; A is read along row i, B down
  // column j.
  mm_store u_store (
    .clk     (clk),
    .we_a    (accept && (cmd.mode == MODE_LOAD_A) && load_ok),
    .we_b    (accept && (cmd.mode == MODE_LOAD_B) && load_ok),
    .waddr   ({cmd.row_index, cmd.col_index}),
    .wdata   (cmd.element_value),
    .raddr_a ({i, k}),
    .raddr_b ({k, j}),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_ctl    (rd_ctl),
    .op_a      (rdata_a),
    .op_b      (rdata_b),
    .res_valid (mac_valid),
    .res       (mac_res)
  );

  // The error strobe is only raised from idle with the pipeline empty, so
  // the two sources never show a result in the same cycle.
  assign result_valid = mac_valid || err_valid;
  assign result       = err_valid ? err_res : mac_res;

  // An error result always closes its run.
  a_err_last : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.dimension_error |-> result.last_element)
    else $error("error result without last_element");

  // Product results only come out of a running compute.
  a_prod_in_run : assert property (@(posedge clk) disable iff (rst)
    mac_valid |-> (state == ST_DRAIN) || (state == ST_RUN))
    else $error("product result outside a compute");

  // The final product element returns the sequencer to idle.
  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    mac_valid && mac_res.last_element |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after last element");

  // Walk counters stay within the latched bounds.
  a_walk_bounds : assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> (k <= n_last) && (j <= p_last) && (i <= m_last))
    else $error("walk counter beyond its bound");

  // Both result sources never fire together.
  a_one_source : assert property (@(posedge clk) disable iff (rst)
    !(mac_valid && err_valid))
    else $error("error and product result collide");

endmodule
